// ===== sv/brd_pkg.sv =====
// ----------------------------------------------------------------------------
// brd_pkg: shared types and codes for the byte ring deque
// Command and status codes, the fixed field widths and the control
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package brd_pkg;

  // Fixed widths of the command and result fields.
  localparam int CMD_W  = 3;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 11;
  localparam int STAT_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PREPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd4;
  localparam logic [CMD_W-1:0] CMD_UNWRITE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNREAD  = 3'd6;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic exec;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

endpackage

// ===== sv/brd_ram.sv =====
// ----------------------------------------------------------------------------
// brd_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module brd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/brd_ctrl.sv =====
// ----------------------------------------------------------------------------
// brd_ctrl: controller for the byte ring deque
// Runs the clearing pass after reset, accepts commands and marks results.
// ----------------------------------------------------------------------------
module brd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  brd_pkg::dp_stat_t   dp_stat,
  output brd_pkg::ctrl_cmd_t  ctrl_cmd,
  output logic                busy,
  output logic                done
);

  brd_pkg::state_t state;
  brd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brd_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    ctrl_cmd.clear_en = 1'b0;
    ctrl_cmd.exec     = 1'b0;
    busy              = 1'b1;
    done              = 1'b0;
    case (state)
      brd_pkg::S_CLEAR: begin
        ctrl_cmd.clear_en = 1'b1;
        if (dp_stat.clear_last) begin
          state_next = brd_pkg::S_IDLE;
        end
      end
      brd_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl_cmd.exec = 1'b1;
          state_next    = brd_pkg::S_RESP;
        end
      end
      brd_pkg::S_RESP: begin
        // The read data of the store is valid in this cycle.
        done       = 1'b1;
        state_next = brd_pkg::S_IDLE;
      end
      default: begin
        state_next = brd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/brd_dp.sv =====
// ----------------------------------------------------------------------------
// brd_dp: datapath for the byte ring deque
// Head and tail pointers, fill count, capacity register, result registers
// and the byte store.
// ----------------------------------------------------------------------------
module brd_dp #(
  parameter int DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  brd_pkg::ctrl_cmd_t           ctrl_cmd,
  output brd_pkg::dp_stat_t            dp_stat,
  input  logic                         cfg_we,
  input  logic [brd_pkg::CNT_W-1:0]    cfg_data,
  input  logic [brd_pkg::CMD_W-1:0]    cmd,
  input  logic [brd_pkg::DATA_W-1:0]   data_in,
  input  logic [brd_pkg::CNT_W-1:0]    amount,
  output logic [brd_pkg::DATA_W-1:0]   data_out,
  output logic [brd_pkg::STAT_W-1:0]   status,
  output logic [brd_pkg::CNT_W-1:0]    moved,
  output logic [brd_pkg::CNT_W-1:0]    fill
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (CW > brd_pkg::CNT_W) ? CW : brd_pkg::CNT_W;
  localparam int SW = AW + 1;
  localparam int CAP_RST = (DEPTH < 1024) ? DEPTH : 1024;

  logic [PW-1:0] head, head_next;
  logic [PW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] cap;
  logic [PW-1:0] clr_idx;

  logic [brd_pkg::STAT_W-1:0] status_next;
  logic [brd_pkg::CNT_W-1:0]  moved_next;
  logic                       hit, hit_next;

  logic                      ram_we;
  logic [PW-1:0]             ram_waddr;
  logic [brd_pkg::DATA_W-1:0] ram_wdata;
  logic [PW-1:0]             ram_raddr;
  logic [brd_pkg::DATA_W-1:0] ram_rdata;

  logic                      ex_we;
  logic [PW-1:0]             ex_waddr;

  logic [SW-1:0] h, t, c, k, a, n, p;
  logic [CW-1:0] cap_wr;
  logic [AW-1:0] count_ext;

  // Advance p by m with wrap at kk; both below or at kk.
  function automatic logic [SW-1:0] fwd(input logic [SW-1:0] pp,
                                        input logic [SW-1:0] m,
                                        input logic [SW-1:0] kk);
    logic [SW-1:0] s;
    s = pp + m;
    if (s >= kk) begin
      s = s - kk;
    end
    return s;
  endfunction

  // Move p back by m with wrap at kk.
  function automatic logic [SW-1:0] back(input logic [SW-1:0] pp,
                                         input logic [SW-1:0] m,
                                         input logic [SW-1:0] kk);
    logic [SW-1:0] s;
    if (pp >= m) begin
      s = pp - m;
    end else begin
      s = pp + kk - m;
    end
    return s;
  endfunction

  assign h = SW'(head);
  assign t = SW'(tail);
  assign c = SW'(count);
  assign k = SW'(cap);
  assign a = SW'(amount);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    status_next = brd_pkg::STAT_OK;
    moved_next  = '0;
    hit_next    = 1'b0;
    ex_we       = 1'b0;
    ex_waddr    = tail;
    ram_raddr   = head;
    n           = '0;
    p           = '0;
    case (cmd)
      brd_pkg::CMD_APPEND: begin
        if (c >= k) begin
          status_next = brd_pkg::STAT_FULL;
        end else begin
          ex_we      = 1'b1;
          ex_waddr   = tail;
          p          = fwd(t, SW'(1), k);
          tail_next  = p[PW-1:0];
          count_next = count + CW'(1);
          moved_next = brd_pkg::CNT_W'(1);
        end
      end
      brd_pkg::CMD_PREPEND: begin
        if (c >= k) begin
          status_next = brd_pkg::STAT_FULL;
        end else begin
          p          = back(h, SW'(1), k);
          ex_we      = 1'b1;
          ex_waddr   = p[PW-1:0];
          head_next  = p[PW-1:0];
          count_next = count + CW'(1);
          moved_next = brd_pkg::CNT_W'(1);
        end
      end
      brd_pkg::CMD_POP: begin
        if (c == '0) begin
          status_next = brd_pkg::STAT_EMPTY;
        end else begin
          ram_raddr  = head;
          hit_next   = 1'b1;
          p          = fwd(h, SW'(1), k);
          head_next  = p[PW-1:0];
          count_next = count - CW'(1);
          moved_next = brd_pkg::CNT_W'(1);
        end
      end
      brd_pkg::CMD_PEEK: begin
        if (a >= c) begin
          status_next = brd_pkg::STAT_EMPTY;
        end else begin
          p         = fwd(h, a, k);
          ram_raddr = p[PW-1:0];
          hit_next  = 1'b1;
        end
      end
      brd_pkg::CMD_DISCARD: begin
        n          = (a < c) ? a : c;
        p          = fwd(h, n, k);
        head_next  = p[PW-1:0];
        count_next = CW'(c - n);
        moved_next = n[brd_pkg::CNT_W-1:0];
      end
      brd_pkg::CMD_UNWRITE: begin
        n          = (a < c) ? a : c;
        p          = back(t, n, k);
        tail_next  = p[PW-1:0];
        count_next = CW'(c - n);
        moved_next = n[brd_pkg::CNT_W-1:0];
      end
      brd_pkg::CMD_UNREAD: begin
        n = k - c;
        if (a < n) begin
          n = a;
        end
        p          = back(h, n, k);
        head_next  = p[PW-1:0];
        count_next = CW'(c + n);
        moved_next = n[brd_pkg::CNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // A written capacity of zero acts as one; above the store depth it is cut.
  always_comb begin
    if (cfg_data == '0) begin
      cap_wr = CW'(1);
    end else if (SW'(cfg_data) > SW'(DEPTH)) begin
      cap_wr = CW'(DEPTH);
    end else begin
      cap_wr = CW'(SW'(cfg_data));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      cap     <= CW'(CAP_RST);
      clr_idx <= '0;
    end else begin
      if (ctrl_cmd.clear_en) begin
        clr_idx <= clr_idx + PW'(1);
      end
      if (cfg_we) begin
        cap   <= cap_wr;
        head  <= '0;
        tail  <= '0;
        count <= '0;
      end else if (ctrl_cmd.exec) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.exec) begin
      status <= status_next;
      moved  <= moved_next;
      hit    <= hit_next;
    end
  end

  assign dp_stat.clear_last = (clr_idx == PW'(DEPTH - 1));

  always_comb begin
    if (ctrl_cmd.clear_en) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else begin
      ram_we    = ctrl_cmd.exec & ex_we;
      ram_waddr = ex_waddr;
      ram_wdata = data_in;
    end
  end

  brd_ram #(
    .WIDTH (brd_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign count_ext = AW'(count);
  assign fill      = count_ext[brd_pkg::CNT_W-1:0];
  assign data_out  = hit ? ram_rdata : '0;

endmodule

// ===== sv/byte_ring_deque.sv =====
// ----------------------------------------------------------------------------
// byte_ring_deque: circular byte store of configurable capacity used as a deque
// Appends, prepends, pops and peeks single bytes, and discards, unwrites or
// unreads clamped runs of bytes, one command per transaction.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                Fields
// command   in         start high, busy low     cmd, data_in, amount
// result    out        done, one cycle          data_out, status, moved, fill
// config    in         cfg_we                   cfg_data (capacity)
//
// A command is taken in the accepting cycle, in which the pointers and
// count are updated and the byte store is accessed, and answered in the
// result cycle, in which done is high. The registered read port of the
// store is why a result cycle is needed; busy stays high in it.
// After reset a clearing pass writes zero to every store byte with busy
// high; capacity writes are taken during it.
// The receiver cannot stall: each result is marked by done for one cycle only.
//
module byte_ring_deque #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [brd_pkg::CMD_W-1:0]   cmd,
  input  logic [brd_pkg::DATA_W-1:0]  data_in,
  input  logic [brd_pkg::CNT_W-1:0]   amount,
  output logic                        done,
  output logic [brd_pkg::DATA_W-1:0]  data_out,
  output logic [brd_pkg::STAT_W-1:0]  status,
  output logic [brd_pkg::CNT_W-1:0]   moved,
  output logic [brd_pkg::CNT_W-1:0]   fill,
  input  logic                        cfg_we,
  input  logic [brd_pkg::CNT_W-1:0]   cfg_data
);

  // The controller only sequences; all state of the ring lives in the
  // datapath, which it drives through the command structure.
  brd_pkg::ctrl_cmd_t ctrl_cmd;
  brd_pkg::dp_stat_t  dp_stat;

  brd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dp_stat  (dp_stat),
    .ctrl_cmd (ctrl_cmd),
    .busy     (busy),
    .done     (done)
  );

  // The datapath holds the pointers, the fill count, the capacity register
  // and the byte store; a capacity write empties the ring but keeps the
  // stored bytes.
  brd_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl_cmd (ctrl_cmd),
    .dp_stat  (dp_stat),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .data_in  (data_in),
    .amount   (amount),
    .data_out (data_out),
    .status   (status),
    .moved    (moved),
    .fill     (fill)
  );

  // A result only ever follows an accepted command in the cycle before.
  a_done_follows_accept : assert property (
    @(posedge clk) disable iff (rst) done |-> $past(start && !busy))
    else $error("result strobe without an accepted command");

  // Every accepted command yields its result in the next cycle.
  a_accept_gives_result : assert property (
    @(posedge clk) disable iff (rst) (start && !busy) |=> done)
    else $error("accepted command gave no result");

  // A byte dropped because the ring is full moves nothing.
  a_full_moves_nothing : assert property (
    @(posedge clk) disable iff (rst)
    (done && status == brd_pkg::STAT_FULL) |-> (moved == '0))
    else $error("full status with bytes moved");

endmodule
